FILE: rtl/i2cms_pkg.sv
// Shared types and constants for the I2C master transaction sequencer.
// Phase encoding, operation and control codes, engine status codes, register indexes.
// No dependencies.
package i2cms_pkg;

  localparam int unsigned WRITE_DEPTH_DEF  = 16;
  localparam int unsigned READ_LEN_MAX_DEF = 255;

  localparam logic [7:0] CFG_RESET_TICKS    = 8'd2;
  localparam logic [6:0] RESET_TARGET_ADDR  = 7'd0;
  localparam logic [7:0] TIMER_MAX          = 8'hFF;

  typedef enum logic [3:0] {
    PH_IDLE          = 4'd0,
    PH_GEN_START     = 4'd1,
    PH_GEN_RESTART   = 4'd2,
    PH_WAIT_START    = 4'd3,
    PH_SLA_W         = 4'd4,
    PH_SLA_R         = 4'd5,
    PH_WAIT_SLA_ACK  = 4'd6,
    PH_SEND_DATA     = 4'd7,
    PH_WAIT_DATA_ACK = 4'd8,
    PH_RECV_ARM      = 4'd9,
    PH_RECV_WAIT     = 4'd10,
    PH_GEN_STOP      = 4'd11,
    PH_WAIT_STOP     = 4'd12
  } phase_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_POLL  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_ACK_TIMEOUT  = 2'd0,
    CFG_STOP_WAIT    = 2'd1,
    CFG_RECV_TIMEOUT = 2'd2
  } cfg_index_t;

  localparam logic [1:0] CTL_KEEP  = 2'd0;
  localparam logic [1:0] CTL_SET   = 2'd1;
  localparam logic [1:0] CTL_CLEAR = 2'd2;

  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RESTART    = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
  localparam logic [7:0] ST_DATA_ACK   = 8'h28;
  localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
  localparam logic [7:0] ST_RX_ACK     = 8'h50;
  localparam logic [7:0] ST_RX_NACK    = 8'h58;

  typedef struct packed {
    logic       busy_res;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       clear_irq;
    logic [7:0] tx_byte;
    logic       write_strobe;
    logic [1:0] ack_ctl;
    logic [1:0] stop_ctl;
    logic [1:0] start_ctl;
  } result_t;

endpackage

FILE: rtl/i2c_master_transaction_sequencer_top.sv
// I2C master transaction sequencer, top level.
// Depends on i2cms_pkg and i2cms_wbuf.
//
// One item is taken per clock while no unaccepted result stalls the input, and gives
// exactly one result; a result register separates the two stream sides, so a new item
// is taken while the previous result waits as long as the result is taken in the same
// cycle. The write bytes sit in a registered-read buffer that is prefetched at the next
// send index, so sending a byte needs no wait for the buffer read. Buffer entries never
// loaded read as undefined. No clearing pass after reset.
module i2c_master_transaction_sequencer_top #(
  parameter int unsigned WRITE_DEPTH  = i2cms_pkg::WRITE_DEPTH_DEF,
  parameter int unsigned READ_LEN_MAX = i2cms_pkg::READ_LEN_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // slave_addr[6:0] mode[7] write_len[12:8] read_len[20:13] byte_in[28:21]
  // irq_flag[29] hw_status[37:30], zero pad [39:38]
  input  logic [39:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // start_ctl[1:0] stop_ctl[3:2] ack_ctl[5:4] write_strobe[6] tx_byte[14:7]
  // clear_irq[15] read_valid[16] read_byte[24:17] busy_res[25], zero pad [31:26]
  output logic [31:0] m_tdata,
  // done_res
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import i2cms_pkg::*;

  localparam int unsigned IW = $clog2(WRITE_DEPTH + 1);
  localparam int unsigned AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  localparam logic [IW-1:0] DEPTH_IDX = IW'(WRITE_DEPTH);

  logic [7:0] ack_timeout_ticks, stop_wait_ticks, receive_timeout_ticks;

  phase_t        phase, phase_next;
  logic          active_mode, active_mode_next;
  logic [6:0]    target_addr, target_addr_next;
  logic [IW-1:0] write_index, write_index_next;
  logic [4:0]    bytes_left_to_send, bytes_left_to_send_next;
  logic [7:0]    bytes_left_to_read, bytes_left_to_read_next;
  logic          timer_enable, timer_enable_next;
  logic [7:0]    timer_count, timer_count_next;

  logic    out_valid;
  result_t out_res, res;
  logic    out_done, done;

  logic       accept;
  op_t        op;
  logic [6:0] slave_addr;
  logic       mode;
  logic [4:0] write_len;
  logic [7:0] read_len, byte_in, hw_status;
  logic       irq_flag;

  logic          buf_we;
  logic [7:0]    buf_rd_data;
  logic          idx_valid;
  logic [IW-1:0] rd_index;

  assign op         = op_t'(s_tuser);
  assign slave_addr = s_tdata[6:0];
  assign mode       = s_tdata[7];
  assign write_len  = s_tdata[12:8];
  assign read_len   = s_tdata[20:13];
  assign byte_in    = s_tdata[28:21];
  assign irq_flag   = s_tdata[29];
  assign hw_status  = s_tdata[37:30];

  assign s_tready  = !out_valid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign idx_valid = write_index < DEPTH_IDX;

  assign buf_we   = accept && (op == OP_LOAD) && (phase == PH_IDLE) && idx_valid;
  assign rd_index = accept ? write_index_next : write_index;

  i2cms_wbuf #(
    .DEPTH (WRITE_DEPTH),
    .AW    (AW)
  ) u_wbuf (
    .clk     (clk),
    .wr_en   (buf_we),
    .wr_addr (write_index[AW-1:0]),
    .wr_data (byte_in),
    .rd_addr (rd_index[AW-1:0]),
    .rd_data (buf_rd_data)
  );

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (op)
      OP_START: begin
        if (phase == PH_IDLE) phase_next = PH_GEN_START;
      end
      OP_POLL: begin
        unique case (phase)
          PH_GEN_START, PH_GEN_RESTART: phase_next = PH_WAIT_START;
          PH_WAIT_START: begin
            if (irq_flag) begin
              priority if (hw_status == ST_START) phase_next = PH_SLA_W;
              else if (hw_status == ST_RESTART && active_mode) phase_next = PH_SLA_R;
              else phase_next = PH_GEN_STOP;
            end
          end
          PH_SLA_W, PH_SLA_R: phase_next = PH_WAIT_SLA_ACK;
          PH_WAIT_SLA_ACK: begin
            if (irq_flag) begin
              priority if (hw_status == ST_SLA_W_ACK) phase_next = PH_SEND_DATA;
              else if (hw_status == ST_SLA_R_ACK && active_mode) phase_next = PH_RECV_ARM;
              else phase_next = PH_GEN_STOP;
            end else if (timer_count >= ack_timeout_ticks) begin
              phase_next = PH_GEN_STOP;
            end
          end
          PH_SEND_DATA: begin
            if (bytes_left_to_send != '0) phase_next = PH_WAIT_DATA_ACK;
            else phase_next = active_mode ? PH_GEN_RESTART : PH_GEN_STOP;
          end
          PH_WAIT_DATA_ACK: begin
            if (irq_flag) begin
              phase_next = (hw_status == ST_DATA_ACK) ? PH_SEND_DATA : PH_GEN_STOP;
            end else if (timer_count >= ack_timeout_ticks) begin
              phase_next = PH_GEN_STOP;
            end
          end
          PH_RECV_ARM: phase_next = PH_RECV_WAIT;
          PH_RECV_WAIT: begin
            if (irq_flag) begin
              phase_next = (hw_status == ST_RX_ACK) ? PH_RECV_ARM : PH_GEN_STOP;
            end else if (timer_count >= receive_timeout_ticks) begin
              phase_next = PH_GEN_STOP;
            end
          end
          PH_GEN_STOP: phase_next = PH_WAIT_STOP;
          PH_WAIT_STOP: begin
            if (timer_count >= stop_wait_ticks) phase_next = PH_IDLE;
          end
          default: phase_next = phase;
        endcase
      end
      default: phase_next = phase;
    endcase
  end

  // Outputs and datapath state
  always_comb begin
    res                     = '0;
    done                    = 1'b0;
    active_mode_next        = active_mode;
    target_addr_next        = target_addr;
    write_index_next        = write_index;
    bytes_left_to_send_next = bytes_left_to_send;
    bytes_left_to_read_next = bytes_left_to_read;
    timer_enable_next       = timer_enable;
    timer_count_next        = timer_count;
    unique case (op)
      OP_LOAD: begin
        if (phase == PH_IDLE && idx_valid) write_index_next = write_index + 1'b1;
      end
      OP_START: begin
        if (phase == PH_IDLE) begin
          target_addr_next        = slave_addr;
          active_mode_next        = mode;
          bytes_left_to_send_next = (32'(write_len) > WRITE_DEPTH) ? 5'(WRITE_DEPTH)
                                                                   : write_len;
          bytes_left_to_read_next = (32'(read_len) > READ_LEN_MAX) ? 8'(READ_LEN_MAX)
                                                                   : read_len;
          write_index_next        = '0;
          timer_count_next        = '0;
          timer_enable_next       = 1'b0;
        end
      end
      OP_POLL: begin
        unique case (phase)
          PH_GEN_START: res.start_ctl = CTL_SET;
          PH_GEN_RESTART: begin
            res.start_ctl = CTL_SET;
            res.clear_irq = 1'b1;
          end
          PH_WAIT_START: begin
            if (irq_flag) res.start_ctl = CTL_CLEAR;
          end
          PH_SLA_W, PH_SLA_R: begin
            res.write_strobe  = 1'b1;
            res.tx_byte       = {target_addr, (phase == PH_SLA_R)};
            res.clear_irq     = 1'b1;
            timer_count_next  = '0;
            timer_enable_next = 1'b1;
          end
          PH_WAIT_SLA_ACK, PH_WAIT_DATA_ACK: begin
            if (irq_flag) begin
              timer_count_next  = '0;
              timer_enable_next = 1'b0;
            end
          end
          PH_SEND_DATA: begin
            if (bytes_left_to_send != '0) begin
              res.write_strobe        = 1'b1;
              res.tx_byte             = idx_valid ? buf_rd_data : 8'd0;
              res.clear_irq           = 1'b1;
              bytes_left_to_send_next = bytes_left_to_send - 1'b1;
              if (idx_valid) write_index_next = write_index + 1'b1;
              timer_count_next        = '0;
              timer_enable_next       = 1'b1;
            end
          end
          PH_RECV_ARM: begin
            timer_count_next  = '0;
            timer_enable_next = 1'b1;
            res.ack_ctl       = (bytes_left_to_read > 8'd1) ? CTL_SET : CTL_CLEAR;
            res.clear_irq     = 1'b1;
          end
          PH_RECV_WAIT: begin
            if (irq_flag && (hw_status == ST_RX_ACK || hw_status == ST_RX_NACK)) begin
              timer_count_next  = '0;
              timer_enable_next = 1'b0;
              res.read_valid    = 1'b1;
              res.read_byte     = byte_in;
              if (hw_status == ST_RX_NACK) bytes_left_to_read_next = '0;
              else if (bytes_left_to_read != '0)
                bytes_left_to_read_next = bytes_left_to_read - 1'b1;
            end
          end
          PH_GEN_STOP: begin
            timer_count_next  = '0;
            timer_enable_next = 1'b1;
            res.stop_ctl      = CTL_SET;
            res.clear_irq     = 1'b1;
          end
          PH_WAIT_STOP: begin
            if (timer_count >= stop_wait_ticks) begin
              timer_count_next  = '0;
              timer_enable_next = 1'b0;
              res.stop_ctl      = CTL_CLEAR;
              done              = 1'b1;
              write_index_next  = '0;
            end
          end
          default: res = '0;
        endcase
      end
      OP_TICK: begin
        if (timer_enable && timer_count < TIMER_MAX) timer_count_next = timer_count + 1'b1;
      end
      default: res = '0;
    endcase
    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      active_mode        <= 1'b0;
      target_addr        <= RESET_TARGET_ADDR;
      write_index        <= '0;
      bytes_left_to_send <= '0;
      bytes_left_to_read <= '0;
      timer_enable       <= 1'b0;
      timer_count        <= '0;
    end else if (accept) begin
      phase              <= phase_next;
      active_mode        <= active_mode_next;
      target_addr        <= target_addr_next;
      write_index        <= write_index_next;
      bytes_left_to_send <= bytes_left_to_send_next;
      bytes_left_to_read <= bytes_left_to_read_next;
      timer_enable       <= timer_enable_next;
      timer_count        <= timer_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout_ticks     <= CFG_RESET_TICKS;
      stop_wait_ticks       <= CFG_RESET_TICKS;
      receive_timeout_ticks <= CFG_RESET_TICKS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ACK_TIMEOUT:  ack_timeout_ticks     <= cfg_data;
        CFG_STOP_WAIT:    stop_wait_ticks       <= cfg_data;
        CFG_RECV_TIMEOUT: receive_timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res  <= res;
      out_done <= done;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_res};
  assign m_tlast  = out_done;

endmodule

FILE: rtl/i2cms_wbuf.sv
// Write byte buffer: single-port-write, registered-read memory.
// A write to the address being read in the same cycle is forwarded. No dependencies.
module i2cms_wbuf #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the I2C master transaction sequencer: a tracker class predicts
// each step from its own copy of the sequencer state and checks every result transfer.
// Depends on i2cms_pkg and the sequencer RTL only.
module testbench;
  import i2cms_pkg::*;

  localparam int    CYCLE_LIMIT   = 400000;
  localparam int    SETTLE_CYCLES = 4;
  localparam int    HOLD_CYCLES   = 40;
  localparam int    NOISE_PCT     = 12;
  localparam int    DEPTH         = WRITE_DEPTH_DEF;

  typedef struct {
    op_t        op;
    logic [6:0] addr;
    logic       mode;
    logic [4:0] wlen;
    logic [7:0] rlen;
    logic [7:0] bin;
    logic       irq;
    logic [7:0] st;
  } item_t;

  typedef struct packed {
    logic    done;
    result_t r;
  } outcome_t;

  class i2c_seq_tracker;
    logic [7:0]  ack_ticks, stop_ticks, recv_ticks;
    phase_t      ph;
    logic        act_mode;
    logic [6:0]  tgt;
    logic [7:0]  wbuf [DEPTH];
    bit          loaded [DEPTH];
    int unsigned wr_idx, send_left, read_left;
    logic        tmr_en;
    logic [7:0]  tmr_cnt;
    bit          restarted, sla_read;
    outcome_t    due_results [$];
    int          errors, checked, finished, bytes_read;

    function new();
      ack_ticks  = CFG_RESET_TICKS;
      stop_ticks = CFG_RESET_TICKS;
      recv_ticks = CFG_RESET_TICKS;
      ph = PH_IDLE;
      act_mode = 1'b0;
      tgt = RESET_TARGET_ADDR;
      wr_idx = 0;
      send_left = 0;
      read_left = 0;
      tmr_en = 1'b0;
      tmr_cnt = '0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function void write_cfg(cfg_index_t idx, logic [7:0] val);
      case (idx)
        CFG_ACK_TIMEOUT:  ack_ticks  = val;
        CFG_STOP_WAIT:    stop_ticks = val;
        CFG_RECV_TIMEOUT: recv_ticks = val;
        default: ;
      endcase
    endfunction

    function int unsigned loaded_count();
      int unsigned n;
      n = 0;
      while (n < DEPTH && loaded[n]) n++;
      return n;
    endfunction

    function void arm_timer();
      tmr_cnt = '0;
      tmr_en = 1'b1;
    endfunction

    function void halt_timer();
      tmr_cnt = '0;
      tmr_en = 1'b0;
    endfunction

    function void poll_step(item_t it, inout outcome_t o);
      case (ph)
        PH_GEN_START: begin
          o.r.start_ctl = CTL_SET;
          ph = PH_WAIT_START;
        end
        PH_GEN_RESTART: begin
          o.r.start_ctl = CTL_SET;
          o.r.clear_irq = 1'b1;
          restarted = 1'b1;
          ph = PH_WAIT_START;
        end
        PH_WAIT_START: if (it.irq) begin
          o.r.start_ctl = CTL_CLEAR;
          if (it.st == ST_START) ph = PH_SLA_W;
          else if (it.st == ST_RESTART && act_mode) ph = PH_SLA_R;
          else ph = PH_GEN_STOP;
        end
        PH_SLA_W, PH_SLA_R: begin
          sla_read = (ph == PH_SLA_R);
          o.r.write_strobe = 1'b1;
          o.r.tx_byte = {tgt, sla_read};
          o.r.clear_irq = 1'b1;
          arm_timer();
          ph = PH_WAIT_SLA_ACK;
        end
        PH_WAIT_SLA_ACK: begin
          if (it.irq) begin
            halt_timer();
            if (it.st == ST_SLA_W_ACK) ph = PH_SEND_DATA;
            else if (it.st == ST_SLA_R_ACK && act_mode) ph = PH_RECV_ARM;
            else ph = PH_GEN_STOP;
          end else if (tmr_cnt >= ack_ticks) begin
            ph = PH_GEN_STOP;
          end
        end
        PH_SEND_DATA: begin
          if (send_left > 0) begin
            o.r.write_strobe = 1'b1;
            o.r.tx_byte = (wr_idx < DEPTH) ? wbuf[wr_idx] : 8'h00;
            o.r.clear_irq = 1'b1;
            send_left--;
            if (wr_idx < DEPTH) wr_idx++;
            arm_timer();
            ph = PH_WAIT_DATA_ACK;
          end else begin
            ph = act_mode ? PH_GEN_RESTART : PH_GEN_STOP;
          end
        end
        PH_WAIT_DATA_ACK: begin
          if (it.irq) begin
            halt_timer();
            ph = (it.st == ST_DATA_ACK) ? PH_SEND_DATA : PH_GEN_STOP;
          end else if (tmr_cnt >= ack_ticks) begin
            ph = PH_GEN_STOP;
          end
        end
        PH_RECV_ARM: begin
          arm_timer();
          o.r.ack_ctl = (read_left > 1) ? CTL_SET : CTL_CLEAR;
          o.r.clear_irq = 1'b1;
          ph = PH_RECV_WAIT;
        end
        PH_RECV_WAIT: begin
          if (it.irq) begin
            if (it.st == ST_RX_ACK || it.st == ST_RX_NACK) begin
              halt_timer();
              o.r.read_valid = 1'b1;
              o.r.read_byte = it.bin;
            end
            if (it.st == ST_RX_ACK) begin
              if (read_left > 0) read_left--;
              ph = PH_RECV_ARM;
            end else begin
              if (it.st == ST_RX_NACK) read_left = 0;
              ph = PH_GEN_STOP;
            end
          end else if (tmr_cnt >= recv_ticks) begin
            ph = PH_GEN_STOP;
          end
        end
        PH_GEN_STOP: begin
          arm_timer();
          o.r.stop_ctl = CTL_SET;
          o.r.clear_irq = 1'b1;
          ph = PH_WAIT_STOP;
        end
        PH_WAIT_STOP: if (tmr_cnt >= stop_ticks) begin
          halt_timer();
          o.r.stop_ctl = CTL_CLEAR;
          o.done = 1'b1;
          wr_idx = 0;
          ph = PH_IDLE;
        end
        default: ;
      endcase
    endfunction

    // Returns 1 for a load or start taken in idle, any poll while busy, or a counting tick.
    function bit note_item(item_t it);
      outcome_t o;
      bit       took;
      o = '0;
      took = 1'b0;
      case (it.op)
        OP_LOAD: if (ph == PH_IDLE && wr_idx < DEPTH) begin
          wbuf[wr_idx] = it.bin;
          loaded[wr_idx] = 1'b1;
          wr_idx++;
          took = 1'b1;
        end
        OP_START: if (ph == PH_IDLE) begin
          tgt = it.addr;
          act_mode = it.mode;
          send_left = (it.wlen > DEPTH) ? DEPTH : it.wlen;
          read_left = (it.rlen > READ_LEN_MAX_DEF) ? READ_LEN_MAX_DEF : it.rlen;
          wr_idx = 0;
          halt_timer();
          restarted = 1'b0;
          ph = PH_GEN_START;
          took = 1'b1;
        end
        OP_POLL: if (ph != PH_IDLE) begin
          poll_step(it, o);
          took = 1'b1;
        end
        default: if (tmr_en && tmr_cnt < TIMER_MAX) begin
          tmr_cnt++;
          took = 1'b1;
        end
      endcase
      o.r.busy_res = (ph != PH_IDLE);
      due_results.push_back(o);
      return took;
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      $error("%s mismatch: expected %h, got %h", field, want, got);
    endfunction

    function void check_result(logic [31:0] data, logic last);
      outcome_t e;
      result_t  got;
      if (due_results.size() == 0) begin
        errors++;
        $error("result transfer with nothing expected: tdata %h tlast %b", data, last);
        return;
      end
      e = due_results.pop_front();
      got = data[25:0];
      checked++;
      if (e.done) finished++;
      if (e.r.read_valid) bytes_read++;
      if (got.start_ctl !== e.r.start_ctl)
        report("start_ctl", 8'(e.r.start_ctl), 8'(got.start_ctl));
      if (got.stop_ctl !== e.r.stop_ctl)
        report("stop_ctl", 8'(e.r.stop_ctl), 8'(got.stop_ctl));
      if (got.ack_ctl !== e.r.ack_ctl)
        report("ack_ctl", 8'(e.r.ack_ctl), 8'(got.ack_ctl));
      if (got.write_strobe !== e.r.write_strobe)
        report("write_strobe", 8'(e.r.write_strobe), 8'(got.write_strobe));
      if (got.tx_byte !== e.r.tx_byte) report("tx_byte", e.r.tx_byte, got.tx_byte);
      if (got.clear_irq !== e.r.clear_irq)
        report("clear_irq", 8'(e.r.clear_irq), 8'(got.clear_irq));
      if (got.read_valid !== e.r.read_valid)
        report("read_valid", 8'(e.r.read_valid), 8'(got.read_valid));
      if (got.read_byte !== e.r.read_byte) report("read_byte", e.r.read_byte, got.read_byte);
      if (got.busy_res !== e.r.busy_res)
        report("busy_res", 8'(e.r.busy_res), 8'(got.busy_res));
      if (last !== e.done) report("done_res", 8'(e.done), 8'(last));
      if (data[31:26] !== 6'b0) report("tdata pad", 8'h00, 8'(data[31:26]));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  i2c_seq_tracker tracker = new();
  int  idle_pct;
  int  hold_reqs;
  int  cycles = 0;
  int  effective_items;
  int  loads_issued;
  int  loads_wanted;

  i2c_master_transaction_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles,
               tracker.due_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tlast);
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    int holds_served;
    stall_left = 0;
    holds_served = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_reqs) begin
        holds_served = hold_reqs;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        stall_left = $urandom_range(7, 1);
      end
      if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic item_t random_item();
    item_t it;
    it.op   = op_t'($urandom_range(3));
    it.addr = 7'($urandom_range(127));
    it.mode = 1'($urandom_range(1));
    it.wlen = 5'($urandom_range(31));
    it.rlen = 8'($urandom_range(255));
    it.bin  = 8'($urandom_range(255));
    it.irq  = 1'($urandom_range(1));
    it.st   = 8'($urandom_range(255));
    return it;
  endfunction

  // Mostly answers the sequencer as a well-behaved engine would; the rest is noise.
  // Starts never send more bytes than have ever been loaded.
  function automatic item_t next_item();
    item_t       it;
    int unsigned filled;
    int          r;
    logic [7:0]  good;
    it = random_item();
    filled = tracker.loaded_count();
    if ($urandom_range(99) < NOISE_PCT) begin
      if (it.op == OP_START && tracker.ph == PH_IDLE && filled < DEPTH && it.wlen > filled)
        it.wlen = 5'($urandom_range(filled));
      return it;
    end
    case (tracker.ph)
      PH_IDLE: begin
        if (loads_issued < loads_wanted) begin
          it.op = OP_LOAD;
          loads_issued++;
        end else begin
          it.op = OP_START;
          if (filled == DEPTH && $urandom_range(7) == 0) it.wlen = 5'($urandom_range(31, 17));
          else it.wlen = 5'($urandom_range(filled));
          r = $urandom_range(99);
          if (r < 1) it.rlen = 8'($urandom_range(255, 100));
          else if (r < 15) it.rlen = 8'($urandom_range(40, 5));
          else it.rlen = 8'($urandom_range(4));
          loads_issued = 0;
          loads_wanted = ($urandom_range(9) == 0) ? DEPTH + 2 : $urandom_range(4);
        end
      end
      PH_WAIT_STOP: begin
        if (tracker.tmr_cnt >= tracker.stop_ticks || $urandom_range(9) == 0) it.op = OP_POLL;
        else it.op = OP_TICK;
      end
      PH_WAIT_START, PH_WAIT_SLA_ACK, PH_WAIT_DATA_ACK, PH_RECV_WAIT: begin
        case (tracker.ph)
          PH_WAIT_START:    good = tracker.restarted ? ST_RESTART : ST_START;
          PH_WAIT_SLA_ACK:  good = tracker.sla_read ? ST_SLA_R_ACK : ST_SLA_W_ACK;
          PH_WAIT_DATA_ACK: good = ST_DATA_ACK;
          default:          good = (tracker.read_left > 1) ? ST_RX_ACK : ST_RX_NACK;
        endcase
        r = $urandom_range(99);
        it.op = (r >= 75 && r < 88) ? OP_TICK : OP_POLL;
        it.irq = (r < 75 || r >= 95);
        if (r < 75) it.st = good;
      end
      default: it.op = OP_POLL;
    endcase
    return it;
  endfunction

  task automatic send_item(item_t it);
    int gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(7, 1);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {2'b00, it.st, it.irq, it.bin, it.rlen, it.wlen, it.mode, it.addr};
    do @(posedge clk); while (!s_tready);
    if (tracker.note_item(it)) effective_items++;
  endtask

  task automatic put(op_t op, logic irq, logic [7:0] st, logic [7:0] bin);
    item_t it;
    it = random_item();
    it.op = op;
    it.irq = irq;
    it.st = st;
    it.bin = bin;
    send_item(it);
  endtask

  task automatic put_start(logic [6:0] addr, logic mode, logic [4:0] wlen, logic [7:0] rlen);
    item_t it;
    it = random_item();
    it.op = OP_START;
    it.addr = addr;
    it.mode = mode;
    it.wlen = wlen;
    it.rlen = rlen;
    send_item(it);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_cfg(idx, val);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_timeouts(logic [7:0] ack_t, logic [7:0] stop_t, logic [7:0] recv_t);
    write_reg(CFG_ACK_TIMEOUT, ack_t);
    write_reg(CFG_STOP_WAIT, stop_t);
    write_reg(CFG_RECV_TIMEOUT, recv_t);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int n_items, bit long_hold);
    int base;
    base = effective_items;
    while (effective_items - base < n_items) begin
      send_item(next_item());
      if (long_hold && effective_items - base == 10) begin
        hold_reqs++;
        long_hold = 1'b0;
      end
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 20;
    hold_reqs = 0;
    effective_items = 0;
    loads_issued = 0;
    loads_wanted = 2;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Write-then-read with reset timeouts: byte extremes, zero read length, idle poll and
    // tick, a start while busy, a wrong status after the restart that forces a stop, timed stop.
    put(OP_LOAD, 1'b0, 8'h00, 8'h00);
    put(OP_LOAD, 1'b1, 8'hFF, 8'hFF);
    put(OP_LOAD, 1'b0, 8'h00, 8'h5A);
    put(OP_POLL, 1'b1, 8'hFF, 8'hFF);
    put(OP_TICK, 1'b0, 8'h00, 8'h00);
    put_start(7'h7F, 1'b1, 5'd2, 8'd0);
    put(OP_POLL, 1'b0, 8'h00, 8'h00);
    put(OP_POLL, 1'b1, ST_START, 8'h00);
    put_start(7'h00, 1'b0, 5'd0, 8'hFF);
    put(OP_POLL, 1'b0, 8'h00, 8'h00);
    put(OP_TICK, 1'b0, 8'h00, 8'h00);
    put(OP_POLL, 1'b1, ST_SLA_W_ACK, 8'h00);
    put(OP_POLL, 1'b0, 8'h00, 8'h00);
    put(OP_POLL, 1'b1, ST_DATA_ACK, 8'h00);
    put(OP_POLL, 1'b0, 8'h00, 8'h00);
    put(OP_POLL, 1'b1, ST_DATA_ACK, 8'h00);
    put(OP_POLL, 1'b0, 8'h00, 8'h00);
    put(OP_POLL, 1'b1, ST_RESTART, 8'h00);
    put(OP_POLL, 1'b0, 8'h00, 8'h00);
    put(OP_POLL, 1'b1, ST_SLA_R_ACK, 8'h00);
    put(OP_POLL, 1'b0, 8'h00, 8'h00);
    put(OP_POLL, 1'b1, ST_RX_NACK, 8'hFF);
    put(OP_POLL, 1'b0, 8'h00, 8'h00);
    put(OP_TICK, 1'b0, 8'h00, 8'h00);
    put(OP_TICK, 1'b0, 8'h00, 8'h00);
    put(OP_POLL, 1'b0, 8'h00, 8'h00);
    drain();

    set_timeouts(8'd1, 8'd1, 8'd1);
    run_phase(350, 1'b1);
    idle_pct = 35;
    set_timeouts(8'd0, 8'd0, 8'd0);
    run_phase(150, 1'b0);
    idle_pct = 10;
    set_timeouts(8'd255, 8'd255, 8'd255);
    run_phase(300, 1'b0);
    idle_pct = 30;
    set_timeouts(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
                 8'($urandom_range(255, 1)));
    run_phase(350, 1'b1);
    idle_pct = 20;
    set_timeouts(8'd2, 8'd255, 8'd1);
    run_phase(250, 1'b0);
    idle_pct = 0;
    set_timeouts(8'($urandom_range(8, 1)), 8'($urandom_range(8, 1)),
                 8'($urandom_range(8, 1)));
    run_phase(500, 1'b0);

    $display("Sent %0d effective items over six timeout settings (zero, one, 255, random)",
             effective_items);
    $display("Checked %0d results: %0d transactions finished, %0d bytes received",
             tracker.checked, tracker.finished, tracker.bytes_read);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: i2c_master_transaction_sequencer_top.f
rtl/i2cms_pkg.sv
rtl/i2cms_wbuf.sv
rtl/i2c_master_transaction_sequencer_top.sv
verif/testbench.sv
